@@ rtl/mt19937_random_generator_core_macros.svh @@
// ----------------------------------------------------------------------------
// MT19937 generator core assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef MT19937_RANDOM_GENERATOR_CORE_MACROS_SVH
`define MT19937_RANDOM_GENERATOR_CORE_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define MTRG_ASSERT_NOW(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define MTRG_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/mtrg_pkg.sv @@
// ----------------------------------------------------------------------------
// MT19937 generator package
// Sizes, generator constants, command codes and shared types.
// ----------------------------------------------------------------------------
package mtrg_pkg;

	localparam int unsigned STATE_WORDS = 624;
	localparam int unsigned SHIFT_DIST  = 397;
	localparam int unsigned IDX_W       = $clog2(STATE_WORDS);
	localparam int unsigned WORD_W      = 32;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [1:0]        cmd_t;

	localparam word_t MATRIX_A   = 32'h9908_b0df;
	localparam word_t UPPER_MASK = 32'h8000_0000;
	localparam word_t LOWER_MASK = 32'h7fff_ffff;
	localparam word_t TEMPER_B   = 32'h9d2c_5680;
	localparam word_t TEMPER_C   = 32'hefc6_0000;
	localparam word_t SEED_MULT  = 32'd1812433253;
	localparam word_t RESET_SEED = 32'd121212;

	localparam cmd_t CMD_DRAW    = 2'd0;
	localparam cmd_t CMD_BOUNDED = 2'd1;
	localparam cmd_t CMD_RESEED  = 2'd2;
	localparam cmd_t CMD_NONE    = 2'd3;

	// One write port and two read ports of the state memory.
	typedef struct packed {
		logic  we;
		idx_t  waddr;
		word_t wdata;
		idx_t  raddr_a;
		idx_t  raddr_b;
	} mem_req_t;

	// Outcome of one twist-and-temper step.
	typedef struct packed {
		word_t new_word;
		word_t result;
		logic  reject;
	} twist_res_t;

endpackage

@@ rtl/mt19937_random_generator_core.sv @@
// ----------------------------------------------------------------------------
// MT19937 random generator core
// 32-bit Mersenne Twister with full-word draws, bounded draws and reseeding.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to issue a command: 0 draws one tempered
// word, 1 draws a uniform value in [0, bound] by masking words to the bit
// span of bound and retrying words above it, 2 reseeds from the seed
// register and answers 0, 3 answers 0 and leaves the state alone. Every
// command returns exactly one word on value, marked by a one-cycle done
// pulse that cannot be held off; take it when it shows. Done comes in a
// cycle where busy is already low, so the next command can be accepted
// while done shows. A bounded draw stays busy and twists the next word
// for each rejected word. The state lives in a 624-word RAM with two read
// ports; each draw twists the word at the read position in place (read
// next and far words, write back the new word), which gives the same
// sequence as a batch twist. A reseed walks the RAM with a registered
// 32x32 multiplier, through a multiply state and an add state per word,
// with busy high throughout. The same walk runs from the reset seed after
// reset, with busy high and no done pulse. Write the seed register only
// while the core is idle; it takes effect at the next reseed.
// ----------------------------------------------------------------------------
module mt19937_random_generator_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  mtrg_pkg::cmd_t  command,
	input  mtrg_pkg::word_t bound,
	output logic            done,
	output mtrg_pkg::word_t value,
	input  logic            cfg_we,
	input  mtrg_pkg::word_t cfg_wdata
);
	import mtrg_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_TWIST = 3'd1;
	localparam logic [2:0] ST_SEED0 = 3'd2;
	localparam logic [2:0] ST_SMUL  = 3'd3;
	localparam logic [2:0] ST_SADD  = 3'd4;

	localparam idx_t LAST_IDX = IDX_W'(STATE_WORDS - 1);
	localparam idx_t FAR_ADD  = IDX_W'(SHIFT_DIST);
	localparam idx_t FAR_SUB  = IDX_W'(STATE_WORDS - SHIFT_DIST);

	logic [2:0] state_q;
	idx_t       pos_q;
	idx_t       seed_k_q;
	logic       ack_q;
	word_t      seed_q;
	word_t      cur_q;
	word_t      p_q;
	word_t      prod_q;
	cmd_t       cmd_q;
	word_t      bound_q;
	word_t      span_q;
	logic       done_q;
	word_t      value_q;

	mem_req_t   mem_req;
	word_t      rd_a;
	word_t      rd_b;
	twist_res_t tw;
	idx_t       pos_inc;
	idx_t       rd_base;
	word_t      seed_word;
	word_t      span_d;
	logic       accept;

	function automatic idx_t idx_inc(input idx_t i);
		idx_inc = (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	function automatic idx_t idx_far(input idx_t i);
		idx_far = (i < FAR_SUB) ? i + FAR_ADD : i - FAR_SUB;
	endfunction

	assign accept    = start && (state_q == ST_IDLE);
	assign pos_inc   = idx_inc(pos_q);
	// during a retry the next word is already being worked on
	assign rd_base   = (state_q == ST_TWIST) ? pos_inc : pos_q;
	assign seed_word = prod_q + WORD_W'(seed_k_q);

	always_comb begin
		span_d = bound;
		span_d = span_d | (span_d >> 1);
		span_d = span_d | (span_d >> 2);
		span_d = span_d | (span_d >> 4);
		span_d = span_d | (span_d >> 8);
		span_d = span_d | (span_d >> 16);
	end

	always_comb begin
		mem_req.raddr_a = idx_inc(rd_base);
		mem_req.raddr_b = idx_far(rd_base);
		mem_req.we      = 1'b0;
		mem_req.waddr   = pos_q;
		mem_req.wdata   = tw.new_word;
		unique case (state_q)
			ST_TWIST: begin
				mem_req.we = 1'b1;
			end
			ST_SEED0: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = '0;
				mem_req.wdata = seed_q;
			end
			ST_SADD: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = seed_k_q;
				mem_req.wdata = seed_word;
			end
			default: begin
				mem_req.we = 1'b0;
			end
		endcase
	end

	mtrg_state_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	mtrg_twist_temper u_twist (
		.cur_word (cur_q),
		.nxt_word (rd_a),
		.far_word (rd_b),
		.cmd      (cmd_q),
		.span     (span_q),
		.bound    (bound_q),
		.res      (tw)
	);

	// seed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= RESET_SEED;
		end else if (cfg_we) begin
			seed_q <= cfg_wdata;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_SEED0;
			pos_q    <= '0;
			seed_k_q <= '0;
			ack_q    <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			// pulse done for the unused command, an accepted word, or the end
			// of a commanded reseed
			done_q <= (accept && (command == CMD_NONE)) ||
				((state_q == ST_TWIST) && !tw.reject) ||
				((state_q == ST_SADD) && (seed_k_q == LAST_IDX) && ack_q);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (command)
							CMD_DRAW, CMD_BOUNDED: begin
								state_q <= ST_TWIST;
							end
							CMD_RESEED: begin
								state_q <= ST_SEED0;
								ack_q   <= 1'b1;
							end
							CMD_NONE: begin
								// answer at once, hold the state
								state_q <= ST_IDLE;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_TWIST: begin
					// advance the read position on every consumed word
					pos_q <= pos_inc;
					if (!tw.reject) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SEED0: begin
					seed_k_q <= IDX_W'(1);
					state_q  <= ST_SMUL;
				end
				ST_SMUL: begin
					state_q <= ST_SADD;
				end
				ST_SADD: begin
					if (seed_k_q == LAST_IDX) begin
						state_q <= ST_IDLE;
						pos_q   <= '0;
						ack_q   <= 1'b0;
					end else begin
						seed_k_q <= seed_k_q + 1'b1;
						state_q  <= ST_SMUL;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= command;
			bound_q <= bound;
			span_q  <= span_d;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (command == CMD_NONE)) begin
					value_q <= '0;
				end
			end
			ST_TWIST: begin
				// carry the next word forward as the new current word
				cur_q <= rd_a;
				if (!tw.reject) begin
					value_q <= tw.result;
				end
			end
			ST_SEED0: begin
				p_q   <= seed_q;
				cur_q <= seed_q;
			end
			ST_SMUL: begin
				prod_q <= SEED_MULT * (p_q ^ (p_q >> 30));
			end
			ST_SADD: begin
				p_q <= seed_word;
				if (seed_k_q == LAST_IDX) begin
					value_q <= '0;
				end
			end
			default: begin
				p_q <= p_q;
			end
		endcase
	end

	assign busy  = (state_q != ST_IDLE);
	assign done  = done_q;
	assign value = value_q;

endmodule

@@ rtl/mtrg_state_mem.sv @@
// ----------------------------------------------------------------------------
// MT19937 state memory
// 624 x 32 synchronous RAM, one write port, two registered read ports.
// ----------------------------------------------------------------------------
module mtrg_state_mem (
	input  logic                clk,
	input  mtrg_pkg::mem_req_t  req,
	output mtrg_pkg::word_t     rdata_a,
	output mtrg_pkg::word_t     rdata_b
);
	import mtrg_pkg::*;

	word_t mem_q [STATE_WORDS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem_q[req.raddr_a];
		rdata_b <= mem_q[req.raddr_b];
	end

endmodule

@@ rtl/mtrg_twist_temper.sv @@
// ----------------------------------------------------------------------------
// MT19937 twist and temper
// Rebuilds one state word, tempers it and applies the bounded-draw mask.
// ----------------------------------------------------------------------------
module mtrg_twist_temper (
	input  mtrg_pkg::word_t      cur_word,
	input  mtrg_pkg::word_t      nxt_word,
	input  mtrg_pkg::word_t      far_word,
	input  mtrg_pkg::cmd_t       cmd,
	input  mtrg_pkg::word_t      span,
	input  mtrg_pkg::word_t      bound,
	output mtrg_pkg::twist_res_t res
);
	import mtrg_pkg::*;

	word_t mix;
	word_t mag;
	word_t t0;
	word_t t1;
	word_t t2;
	word_t tempered;
	word_t masked;

	always_comb begin
		mix          = (cur_word & UPPER_MASK) | (nxt_word & LOWER_MASK);
		mag          = nxt_word[0] ? MATRIX_A : '0;
		res.new_word = far_word ^ (mix >> 1) ^ mag;

		t0       = res.new_word ^ (res.new_word >> 11);
		t1       = t0 ^ ((t0 << 7) & TEMPER_B);
		t2       = t1 ^ ((t1 << 15) & TEMPER_C);
		tempered = t2 ^ (t2 >> 18);

		// keep only the bit span of the bound, retry if above it
		masked     = tempered & span;
		res.reject = (cmd == CMD_BOUNDED) && (masked > bound);
		res.result = (cmd == CMD_BOUNDED) ? masked : tempered;
	end

endmodule

@@ rtl/mtrg_checker.sv @@
// ----------------------------------------------------------------------------
// MT19937 generator port checker
// Port-level properties of the command handshake and result strobe.
// ----------------------------------------------------------------------------
`include "mt19937_random_generator_core_macros.svh"

module mtrg_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input mtrg_pkg::cmd_t  command,
	input logic            done,
	input mtrg_pkg::word_t value
);
	import mtrg_pkg::*;

	logic acc_work;
	logic acc_none;
	logic acc_reseed;

	assign acc_work = start && !busy &&
		(command == CMD_DRAW || command == CMD_BOUNDED || command == CMD_RESEED);
	assign acc_none   = start && !busy && (command == CMD_NONE);
	assign acc_reseed = start && !busy && (command == CMD_RESEED);

	`MTRG_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy, "result while busy")
	`MTRG_ASSERT_NEXT(a_work_busy, clk, arst_n, acc_work, busy && !done,
		"command did not hold busy")
	`MTRG_ASSERT_NEXT(a_none_ack, clk, arst_n, acc_none, done && (value == '0),
		"unused command not answered with zero")
	`MTRG_ASSERT_NEXT(a_reseed_long, clk, arst_n, $past(acc_reseed), !done,
		"reseed answered too early")

endmodule

bind mt19937_random_generator_core mtrg_checker u_mtrg_checker (.*);

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MT19937 generator core testbench
// Issues full-word draws, bounded draws, reseeds and the unused command.
// Every accepted command is predicted by a model of the 624-word state kept
// here, and each done word is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

	import mtrg_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned TAIL_CYCLES = 40;

	// One predicted word, with the command that caused it for the log.
	typedef struct {
		cmd_t  cmd;
		word_t bnd;
		word_t value;
	} draw_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  start = 1'b0;
	logic  busy;
	cmd_t  command = CMD_DRAW;
	word_t bound = '0;
	logic  done;
	word_t value;
	logic  cfg_we = 1'b0;
	word_t cfg_wdata = '0;

	// Predicted generator state and seed register.
	word_t       mt_state [STATE_WORDS];
	int unsigned mt_pos;
	int unsigned mt_left;
	word_t       seed_reg;

	draw_t       pending_draws[$];
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	int unsigned send_idle_pct = 0;

	mt19937_random_generator_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.command   (command),
		.bound     (bound),
		.done      (done),
		.value     (value),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Give up on a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Regenerate all 624 words in one batch; the core does it word by word,
	// which yields the same sequence.
	function automatic void twist_state();
		word_t y;
		word_t nxt;
		word_t far_w;
		for (int k = 0; k < STATE_WORDS; k++) begin
			nxt   = mt_state[(k + 1) % STATE_WORDS];
			far_w = mt_state[(k + SHIFT_DIST) % STATE_WORDS];
			y     = (mt_state[k] & UPPER_MASK) | (nxt & LOWER_MASK);
			mt_state[k] = far_w ^ (y >> 1) ^ (nxt[0] ? MATRIX_A : word_t'(0));
		end
		mt_left = STATE_WORDS;
		mt_pos  = 0;
	endfunction

	// Multiplier walk from the seed, then one twist.
	function automatic void seed_state(input word_t seed);
		word_t p;
		mt_state[0] = seed;
		for (int k = 1; k < STATE_WORDS; k++) begin
			p = mt_state[k - 1];
			mt_state[k] = SEED_MULT * (p ^ (p >> 30)) + word_t'(k);
		end
		twist_state();
	endfunction

	function automatic word_t next_tempered();
		word_t y;
		if (mt_left == 0 || mt_pos >= STATE_WORDS)
			twist_state();
		mt_left--;
		y = mt_state[mt_pos];
		mt_pos++;
		y ^= y >> 11;
		y ^= (y << 7) & TEMPER_B;
		y ^= (y << 15) & TEMPER_C;
		y ^= y >> 18;
		return y;
	endfunction

	// Mask to the bit span of the bound and retry words above it.
	function automatic word_t bounded_draw(input word_t bnd);
		word_t span;
		word_t v;
		span = bnd;
		span |= span >> 1;
		span |= span >> 2;
		span |= span >> 4;
		span |= span >> 8;
		span |= span >> 16;
		do
			v = next_tempered() & span;
		while (v > bnd);
		return v;
	endfunction

	function automatic word_t predict_word(input cmd_t cmd, input word_t bnd);
		case (cmd)
			CMD_DRAW:    return next_tempered();
			CMD_BOUNDED: return bounded_draw(bnd);
			CMD_RESEED: begin
				seed_state(seed_reg);
				return '0;
			end
			default:     return '0;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Checking: done cannot be held off, so take every word as it shows
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		error_count++;
	endtask

	always @(posedge clk) begin : check_words
		draw_t exp_w;
		if (arst_n && done === 1'b1) begin
			if (pending_draws.size() == 0) begin
				report_mismatch($sformatf("word %08h with nothing pending", value));
			end else begin
				exp_w = pending_draws.pop_front();
				if (value !== exp_w.value)
					report_mismatch($sformatf("cmd %0d bound %08h: value %08h, want %08h",
						exp_w.cmd, exp_w.bnd, value, exp_w.value));
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Issue one command. Hold start high through back-to-back words; drop it
	// only for an idle gap. Returns at the edge that accepted the word.
	task automatic send_word(input cmd_t cmd, input word_t bnd);
		if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start   <= 1'b1;
		command <= cmd;
		bound   <= bnd;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		pending_draws.push_back('{cmd, bnd, predict_word(cmd, bnd)});
	endtask

	// Drop start and wait until every predicted word has come back and the
	// core is idle, then a few cycles more.
	task automatic drain_words();
		start <= 1'b0;
		while (pending_draws.size() != 0)
			@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_seed(input word_t seed);
		drain_words();
		cfg_we    <= 1'b1;
		cfg_wdata <= seed;
		@(posedge clk);
		cfg_we    <= 1'b0;
		seed_reg   = seed;
	endtask

	function automatic word_t random_bound();
		int unsigned sh;
		sh = $urandom_range(0, 31);
		case ($urandom_range(0, 4))
			0:       return $urandom_range(0, 15);
			// Powers of two reject almost half of the words.
			1:       return word_t'(1) << sh;
			2:       return (word_t'(1) << sh) - 1;
			3:       return (word_t'(1) << sh) + 1;
			default: return $urandom();
		endcase
	endfunction

	function automatic cmd_t random_cmd();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 44)
			return CMD_DRAW;
		if (r < 90)
			return CMD_BOUNDED;
		if (r < 93)
			return CMD_RESEED;
		return CMD_NONE;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// First words after reset come from the reset seed.
	task automatic test_reset_stream();
		repeat (4) send_word(CMD_DRAW, $urandom());
	endtask

	// Empty bit span, all ones, single top bit and its neighbors.
	task automatic test_bound_edges();
		send_word(CMD_BOUNDED, 32'h0000_0000);
		send_word(CMD_BOUNDED, 32'h0000_0001);
		send_word(CMD_BOUNDED, 32'h0000_0002);
		send_word(CMD_BOUNDED, 32'h0000_0003);
		send_word(CMD_BOUNDED, 32'hffff_ffff);
		send_word(CMD_BOUNDED, 32'h8000_0000);
		send_word(CMD_BOUNDED, 32'h7fff_ffff);
		send_word(CMD_BOUNDED, 32'h8000_0001);
	endtask

	// The unused command answers 0 and must not advance the state.
	task automatic test_unused_command();
		send_word(CMD_NONE, 32'hffff_ffff);
		send_word(CMD_NONE, 32'h0000_0000);
		send_word(CMD_DRAW, 32'h0);
	endtask

	// Seed register extremes; a write alone must not touch the state.
	task automatic test_reseed_extremes();
		write_seed(32'h0000_0000);
		send_word(CMD_DRAW, 32'h0);
		send_word(CMD_RESEED, 32'h0);
		send_word(CMD_DRAW, 32'h0);
		write_seed(32'hffff_ffff);
		send_word(CMD_RESEED, 32'hffff_ffff);
		send_word(CMD_BOUNDED, 32'h0000_00ff);
	endtask

	// Mixed random commands; the stream runs through many twists.
	task automatic test_random_mix(input int unsigned idle_pct, input int unsigned count);
		send_idle_pct = idle_pct;
		for (int unsigned i = 0; i < count; i++) begin
			// Hold off now and then until every pending word is back.
			if (i == count / 2 || $urandom_range(0, 99) == 0)
				drain_words();
			send_word(random_cmd(), random_bound());
		end
		send_idle_pct = 0;
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		seed_reg = RESET_SEED;
		seed_state(RESET_SEED);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// The core reseeds itself after reset, with busy high from reset; wait for it to clear.
		repeat (3) @(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);

		test_reset_stream();
		test_bound_edges();
		test_unused_command();
		test_reseed_extremes();

		write_seed($urandom());
		test_random_mix(30, 500);
		write_seed($urandom());
		test_random_mix(61, 500);
		write_seed(RESET_SEED);
		test_random_mix(0, 500);

		drain_words();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0 && pending_draws.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
